FILE: rtl/uirb_pkg.sv
`default_nettype none

package uirb_pkg;

  localparam int unsigned QueueDepth = 256;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned StatusW    = 3;

  typedef enum logic [1:0] {
    OpPut  = 2'd0,
    OpGet  = 2'd1,
    OpTxEv = 2'd2,
    OpRxEv = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StDone    = 3'd0,
    StTxFull  = 3'd1,
    StRxEmpty = 3'd2,
    StTxIdle  = 3'd3,
    StRxFull  = 3'd4
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/uirb_in_if.sv
`default_nettype none

interface uirb_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [uirb_pkg::ByteW-1:0]   data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink (input valid, input op, input data_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/uirb_out_if.sv
`default_nettype none

interface uirb_out_if;
  logic                           valid;
  logic                           ready;
  logic [uirb_pkg::StatusW-1:0]   status;
  logic [uirb_pkg::ByteW-1:0]     data_out;
  logic                           line_write;
  logic                           data_valid;
  logic                           tx_irq_on;
  logic                           rx_irq_on;

  modport source (
    output valid, output status, output data_out, output line_write,
    output data_valid, output tx_irq_on, output rx_irq_on, input ready
  );
  modport sink (
    input valid, input status, input data_out, input line_write,
    input data_valid, input tx_irq_on, input rx_irq_on, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/uirb_ram.sv
`default_nettype none

module uirb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uirb_front.sv
`default_nettype none

module uirb_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  uirb_in_if.sink             in_i,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  output uirb_pkg::cmd_t      cmd_o
);

  // two-entry queue between intake and execution
  uirb_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;
  uirb_pkg::cmd_t cmd_in;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    cmd_in.op   = uirb_pkg::op_e'(in_i.op);
    cmd_in.data = in_i.data_in;
    wr_ptr_d    = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d    = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d       = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uirb_back.sv
`default_nettype none

module uirb_back #(
  parameter int unsigned Depth = uirb_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wire uirb_pkg::cmd_t  cmd_i,
  uirb_out_if.source           out_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);

  function automatic logic [AddrW-1:0] next_idx(input logic [AddrW-1:0] idx);
    next_idx = (idx == LastIdx) ? '0 : idx + AddrW'(1);
  endfunction

  logic [AddrW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [AddrW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic             tx_en_q, tx_en_d, rx_en_q, rx_en_d;

  logic             res_valid_q, res_valid_d;
  uirb_pkg::status_e status_q, status_d;
  logic             line_q, line_d, dv_q, dv_d;

  logic             fire;
  logic             tx_we, tx_re, rx_we, rx_re;
  logic [uirb_pkg::ByteW-1:0] tx_rdata, rx_rdata;

  assign cmd_ready_o = !res_valid_q || out_o.ready;
  assign fire        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    tx_head_d   = tx_head_q;
    tx_tail_d   = tx_tail_q;
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    tx_en_d     = tx_en_q;
    rx_en_d     = rx_en_q;
    status_d    = status_q;
    line_d      = line_q;
    dv_d        = dv_q;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    res_valid_d = res_valid_q && !out_o.ready;
    if (fire) begin
      res_valid_d = 1'b1;
      status_d    = uirb_pkg::StDone;
      line_d      = 1'b0;
      dv_d        = 1'b0;
      unique case (cmd_i.op)
        uirb_pkg::OpPut: begin
          tx_en_d = 1'b1;
          if (next_idx(tx_tail_q) == tx_head_q) begin
            status_d = uirb_pkg::StTxFull;
          end else begin
            tx_we     = 1'b1;
            tx_tail_d = next_idx(tx_tail_q);
          end
        end
        uirb_pkg::OpGet: begin
          if (rx_head_q == rx_tail_q) begin
            rx_en_d  = 1'b1;
            status_d = uirb_pkg::StRxEmpty;
          end else begin
            rx_re     = 1'b1;
            dv_d      = 1'b1;
            rx_head_d = next_idx(rx_head_q);
          end
        end
        uirb_pkg::OpTxEv: begin
          if (tx_head_q == tx_tail_q) begin
            tx_en_d  = 1'b0;
            status_d = uirb_pkg::StTxIdle;
          end else begin
            tx_re     = 1'b1;
            line_d    = 1'b1;
            tx_head_d = next_idx(tx_head_q);
            tx_en_d   = 1'b1;
          end
        end
        uirb_pkg::OpRxEv: begin
          if (next_idx(rx_tail_q) == rx_head_q) begin
            rx_en_d  = 1'b0;
            status_d = uirb_pkg::StRxFull;
          end else begin
            rx_we     = 1'b1;
            rx_tail_d = next_idx(rx_tail_q);
          end
        end
      endcase
    end
  end

  uirb_ram #(.Width(uirb_pkg::ByteW), .Depth(Depth)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_tail_q),
    .wdata_i (cmd_i.data),
    .re_i    (tx_re),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  uirb_ram #(.Width(uirb_pkg::ByteW), .Depth(Depth)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_tail_q),
    .wdata_i (cmd_i.data),
    .re_i    (rx_re),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_en_q     <= 1'b0;
      rx_en_q     <= 1'b0;
      res_valid_q <= 1'b0;
      status_q    <= uirb_pkg::StDone;
      line_q      <= 1'b0;
      dv_q        <= 1'b0;
    end else begin
      tx_head_q   <= tx_head_d;
      tx_tail_q   <= tx_tail_d;
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      tx_en_q     <= tx_en_d;
      rx_en_q     <= rx_en_d;
      res_valid_q <= res_valid_d;
      status_q    <= status_d;
      line_q      <= line_d;
      dv_q        <= dv_d;
    end
  end

  // RAM read data is held until the next read, which only follows a handoff
  assign out_o.valid      = res_valid_q;
  assign out_o.status     = status_q;
  assign out_o.line_write = line_q;
  assign out_o.data_valid = dv_q;
  assign out_o.tx_irq_on  = tx_en_q;
  assign out_o.rx_irq_on  = rx_en_q;
  assign out_o.data_out   = line_q ? tx_rdata : (dv_q ? rx_rdata : '0);

endmodule

`default_nettype wire

FILE: rtl/uart_interrupt_ring_buffers_unit.sv
// UART transmit/receive byte ring queues with interrupt enable flags.
// Input channel in_i carries one operation per item: put a transmit byte,
// get a received byte, transmitter-ready event, or byte-received event.
// Output channel out_o returns exactly one result item per input item, in
// order: status, the byte popped or sent to the line, and both enable flags.
// Each queue holds QueueDepth - 1 bytes; one slot always stays free.
// Each item enters the two-entry intake queue when accepted, then executes
// into the registered result; queue memories read registered.
// Throughput: one item per cycle while out_o is ready; each item does one
// pointer compare and at most one access to one queue memory.
// Reset clears pointers, flags and the intake queue; queue storage is not
// cleared and is never read before it is written.
// When out_o stalls, the finished result is held, execution stops, and the
// intake queue absorbs up to two more items before in_i.ready drops.
`default_nettype none

module uart_interrupt_ring_buffers_unit #(
  parameter int unsigned QueueDepth = uirb_pkg::QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  uirb_in_if.sink   in_i,
  uirb_out_if.source out_o
);

  logic           cmd_valid;
  logic           cmd_ready;
  uirb_pkg::cmd_t cmd;

  uirb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  uirb_back #(.Depth(QueueDepth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Depth     = uirb_pkg::QueueDepth;
  localparam int unsigned ByteW     = uirb_pkg::ByteW;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldLen   = 300;

  typedef struct packed {
    uirb_pkg::status_e status;
    logic [ByteW-1:0]  data;
    logic              line_write;
    logic              data_valid;
    logic              tx_irq;
    logic              rx_irq;
  } result_t;

  logic clk_i;
  logic rst_ni;

  uirb_in_if  in_if ();
  uirb_out_if out_if ();

  uart_interrupt_ring_buffers_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // predicted queue contents and flags
  logic [ByteW-1:0] tx_mem [Depth];
  logic [ByteW-1:0] rx_mem [Depth];
  int unsigned tx_rd = 0, tx_wr = 0, rx_rd = 0, rx_wr = 0;
  bit tx_irq = 1'b0, rx_irq = 1'b0;

  result_t due_results [$];
  result_t want;
  int errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cycles = 0;
  int unsigned stall_left = 0;
  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;

  function automatic int unsigned wrap_inc(int unsigned i);
    return (i + 1 == Depth) ? 0 : i + 1;
  endfunction

  function automatic bit tx_full();
    return wrap_inc(tx_wr) == tx_rd;
  endfunction

  function automatic bit rx_full();
    return wrap_inc(rx_wr) == rx_rd;
  endfunction

  function automatic result_t queue_step(uirb_pkg::op_e op, logic [ByteW-1:0] b);
    result_t r;
    r = '0;
    r.status = uirb_pkg::StDone;
    case (op)
      uirb_pkg::OpPut: begin
        if (tx_full()) begin
          r.status = uirb_pkg::StTxFull;
        end else begin
          tx_mem[tx_wr] = b;
          tx_wr = wrap_inc(tx_wr);
        end
        tx_irq = 1'b1;
      end
      uirb_pkg::OpGet: begin
        if (rx_rd == rx_wr) begin
          rx_irq = 1'b1;
          r.status = uirb_pkg::StRxEmpty;
        end else begin
          r.data = rx_mem[rx_rd];
          r.data_valid = 1'b1;
          rx_rd = wrap_inc(rx_rd);
        end
      end
      uirb_pkg::OpTxEv: begin
        if (tx_rd == tx_wr) begin
          tx_irq = 1'b0;
          r.status = uirb_pkg::StTxIdle;
        end else begin
          r.data = tx_mem[tx_rd];
          r.line_write = 1'b1;
          tx_rd = wrap_inc(tx_rd);
          tx_irq = 1'b1;
        end
      end
      default: begin
        if (rx_full()) begin
          rx_irq = 1'b0;
          r.status = uirb_pkg::StRxFull;
        end else begin
          rx_mem[rx_wr] = b;
          rx_wr = wrap_inc(rx_wr);
        end
      end
    endcase
    r.tx_irq = tx_irq;
    r.rx_irq = rx_irq;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = uirb_pkg::OpPut;
    in_if.data_in = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // result side: random stalls plus the long hold-off
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
        if (sink_stalls) stall_left = pick_gap();
      end
    end
  end

  task automatic report(string name, int exp_v, int act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, status %0h data %0h",
                 $time, out_if.status, out_if.data_out);
      end else begin
        want = due_results.pop_front();
        if (out_if.status !== want.status) report("status", want.status, out_if.status);
        if (out_if.data_out !== want.data) report("data_out", want.data, out_if.data_out);
        if (out_if.line_write !== want.line_write)
          report("line_write", want.line_write, out_if.line_write);
        if (out_if.data_valid !== want.data_valid)
          report("data_valid", want.data_valid, out_if.data_valid);
        if (out_if.tx_irq_on !== want.tx_irq) report("tx_irq_on", want.tx_irq, out_if.tx_irq_on);
        if (out_if.rx_irq_on !== want.rx_irq) report("rx_irq_on", want.rx_irq, out_if.rx_irq_on);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("[uart_interrupt_ring_buffers_unit] ERROR");
        $finish;
      end
    end
  end

  // enters and leaves at a falling edge; valid stays high after the item
  task automatic send_cmd(uirb_pkg::op_e op, logic [ByteW-1:0] b);
    int unsigned gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.op = op;
    in_if.data_in = b;
    do @(posedge clk_i); while (!in_if.ready);
    due_results.push_back(queue_step(op, b));
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_cmd(uirb_pkg::OpGet, 8'hFF);
    send_cmd(uirb_pkg::OpTxEv, 8'hFF);
    send_cmd(uirb_pkg::OpPut, 8'h00);
    send_cmd(uirb_pkg::OpPut, 8'hFF);
    send_cmd(uirb_pkg::OpPut, 8'h80);
    send_cmd(uirb_pkg::OpPut, 8'h01);
    repeat (4) send_cmd(uirb_pkg::OpTxEv, 8'h00);
    send_cmd(uirb_pkg::OpTxEv, 8'h3C);
    send_cmd(uirb_pkg::OpRxEv, 8'h00);
    send_cmd(uirb_pkg::OpRxEv, 8'hFF);
    send_cmd(uirb_pkg::OpRxEv, 8'h7F);
    send_cmd(uirb_pkg::OpRxEv, 8'h01);
    repeat (4) send_cmd(uirb_pkg::OpGet, 8'h00);
    send_cmd(uirb_pkg::OpGet, 8'hA5);
    send_cmd(uirb_pkg::OpRxEv, 8'hAA);
    send_cmd(uirb_pkg::OpGet, 8'h55);
  endtask

  task automatic test_tx_fill();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    while (!tx_full()) send_cmd(uirb_pkg::OpPut, 8'($urandom));
    repeat (3) send_cmd(uirb_pkg::OpPut, 8'($urandom));
    while (tx_rd != tx_wr) send_cmd(uirb_pkg::OpTxEv, 8'($urandom));
    repeat (2) send_cmd(uirb_pkg::OpTxEv, 8'($urandom));
  endtask

  task automatic test_rx_fill();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    while (!rx_full()) send_cmd(uirb_pkg::OpRxEv, 8'($urandom));
    repeat (3) send_cmd(uirb_pkg::OpRxEv, 8'($urandom));
    while (rx_rd != rx_wr) send_cmd(uirb_pkg::OpGet, 8'($urandom));
    repeat (2) send_cmd(uirb_pkg::OpGet, 8'($urandom));
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_cycles = HoldLen;
    repeat (60) send_cmd(uirb_pkg::op_e'($urandom_range(0, 3)), 8'($urandom));
  endtask

  // biased segments lean toward filling or draining one queue so both reach deep levels
  task automatic test_random(int unsigned segments);
    int unsigned bias;
    int unsigned r;
    uirb_pkg::op_e op;
    uirb_pkg::op_e any_op;
    repeat (segments) begin
      bias = $urandom_range(0, 4);
      src_gaps = $urandom_range(0, 2) != 0;
      sink_stalls = $urandom_range(0, 2) != 0;
      repeat (40) begin
        r = $urandom_range(0, 99);
        any_op = uirb_pkg::op_e'($urandom_range(0, 3));
        case (bias)
          1: op = (r < 70) ? uirb_pkg::OpPut : (r < 85) ? uirb_pkg::OpTxEv : any_op;
          2: op = (r < 70) ? uirb_pkg::OpTxEv : (r < 85) ? uirb_pkg::OpPut : any_op;
          3: op = (r < 70) ? uirb_pkg::OpRxEv : (r < 85) ? uirb_pkg::OpGet : any_op;
          4: op = (r < 70) ? uirb_pkg::OpGet : (r < 85) ? uirb_pkg::OpRxEv : any_op;
          default: op = any_op;
        endcase
        send_cmd(op, 8'($urandom));
      end
    end
  endtask

  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    test_directed();
    test_tx_fill();
    test_rx_fill();
    test_backpressure();
    test_random(10);
    in_if.valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[uart_interrupt_ring_buffers_unit] OK");
    end else begin
      $display("[uart_interrupt_ring_buffers_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/uirb_pkg.sv
rtl/uirb_in_if.sv
rtl/uirb_out_if.sv
rtl/uirb_ram.sv
rtl/uirb_front.sv
rtl/uirb_back.sv
rtl/uart_interrupt_ring_buffers_unit.sv
tb/sv/tb.sv
